>>> design/pida_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array package
// Shared constants, codes and payload types of the ordered list block.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int CAPACITY   = 128;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int LEN_W      = 8;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADPOS = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } out_item_t;

  typedef struct packed {
    logic             exec;
    logic             ins;
    logic             del;
    logic             rd;
    logic [CMP_W-1:0] tgt;
  } cell_ctrl_t;

endpackage

>>> design/positional_insert_delete_array_top.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array
// Ordered list of signed 32-bit entries kept in a row of shifting cells.
//
// Each operation passes through three stages between its input transfer and a
// valid result: a stage in which every cell of the row shifts, loads or holds
// and the count is updated, a stage in the registered group level of the read
// select tree, and a stage, held while the output register is not drained, for
// the final OR into the output register. A new item is taken only once the
// previous result has entered the output register, so the block does not take
// a new item before it is through with the last one.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_top
  import pida_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  in_item_t         item;
  logic [1:0]       status;
  logic [1:0]       status_next;
  cell_ctrl_t       ctrl;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_nonzero;
  logic             ins_ok;
  logic             acc_ok;
  logic             is_full;
  logic             out_load;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_rd;
  logic [DATA_W-1:0]               rd_result;

  assign in_ready    = (state == S_IDLE);
  assign pos_ext     = CMP_W'(item.position);
  assign cnt_ext     = CMP_W'(count);
  assign pos_nonzero = (item.position != '0);
  assign ins_ok      = pos_nonzero && (pos_ext <= cnt_ext + CMP_W'(1));
  assign acc_ok      = pos_nonzero && (pos_ext <= cnt_ext);
  assign is_full     = (count == CNT_W'(CAPACITY));
  assign out_load    = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    ctrl        = '0;
    ctrl.tgt    = pos_ext - CMP_W'(1);
    status_next = STATUS_BADPOS;
    count_next  = count;
    if (state == S_EXEC) begin
      ctrl.exec = 1'b1;
      case (item.mode)
        MODE_INSERT: begin
          if (ins_ok) begin
            if (is_full) begin
              status_next = STATUS_FULL;
            end else begin
              ctrl.ins    = 1'b1;
              count_next  = count + CNT_W'(1);
              status_next = STATUS_OK;
            end
          end
        end
        MODE_DELETE: begin
          if (acc_ok) begin
            ctrl.del    = 1'b1;
            count_next  = count - CNT_W'(1);
            status_next = STATUS_OK;
          end
        end
        MODE_READ: begin
          if (acc_ok) begin
            ctrl.rd     = 1'b1;
            status_next = STATUS_OK;
          end
        end
        default: begin
          status_next = STATUS_BADPOS;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_RED;
      S_RED:  state_next = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (state == S_EXEC) begin
      status <= status_next;
    end
    if (out_load) begin
      out_data.status     <= status;
      out_data.read_value <= rd_result;
      out_data.length     <= LEN_W'(count);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    pida_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .ins_value  (item.value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .rd_gated   (cell_rd[i])
    );
  end

  pida_reduce u_reduce (
    .clk    (clk),
    .load   (state == S_RED),
    .lanes  (cell_rd),
    .result (rd_result)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted transfer did not start execution");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.del |=> (count == $past(count) - CNT_W'(1)))
    else $error("delete did not shrink the list by one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_load && (status == STATUS_FULL)) |-> is_full)
    else $error("full status reported on a list that is not full");

endmodule

>>> design/pida_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one entry; shifts from a neighbour, loads the new value or holds.
// ----------------------------------------------------------------------------
module pida_cell
  import pida_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [DATA_W-1:0] ins_value,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_gated
);

  logic [CMP_W-1:0] idx_ext;
  logic             at_pos;
  logic             after_pos;

  assign idx_ext   = CMP_W'(idx);
  assign at_pos    = (idx_ext == ctrl.tgt);
  assign after_pos = (idx_ext > ctrl.tgt);

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      if (ctrl.ins && at_pos) begin
        data <= ins_value;
      end else if (ctrl.ins && after_pos) begin
        data <= left_data;
      end else if (ctrl.del && (at_pos || after_pos)) begin
        data <= right_data;
      end
      rd_gated <= (ctrl.rd && at_pos) ? data : '0;
    end
  end

endmodule

>>> design/pida_reduce.sv
// ----------------------------------------------------------------------------
// Read select tree
// Two-level OR tree over the gated cell outputs; the group level is registered.
// ----------------------------------------------------------------------------
module pida_reduce
  import pida_pkg::*;
(
  input  logic                             clk,
  input  logic                             load,
  input  logic [CAPACITY-1:0][DATA_W-1:0]  lanes,
  output logic [DATA_W-1:0]                result
);

  logic [NUM_GROUPS-1:0][DATA_W-1:0] group_or;
  logic [NUM_GROUPS-1:0][DATA_W-1:0] group_or_next;

  always_comb begin
    group_or_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_or_next[g] = group_or_next[g] | lanes[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      group_or <= group_or_next;
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      result = result | group_or[g];
    end
  end

endmodule
